[rtl/qfpi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfpi_pkg: shared constants and functions for the field product integrator
// Kinds, register indexes, default sizes and fixed-point helper functions.
// ----------------------------------------------------------------------------
package qfpi_pkg;

	localparam int MaxNodesDef = 32;
	localparam int MaxQuadDef  = 32;

	localparam logic [1:0] KIND_MATRIX = 2'd0;
	localparam logic [1:0] KIND_WEIGHT = 2'd1;
	localparam logic [1:0] KIND_SAMPLE = 2'd2;

	localparam logic [0:0] REG_NUM_NODES = 1'b0;
	localparam logic [0:0] REG_NUM_QUAD  = 1'b1;

	// Round a Q18.46 product to Q.16 (add half, arithmetic shift by 30)
	function automatic logic signed [33:0] round_q16(input logic signed [63:0] p);
		logic signed [63:0] r;
		begin
			r = (p + 64'sd536870912) >>> 30;
			round_q16 = r[33:0];
		end
	endfunction

	// Saturate a 64-bit sum to signed 32 bits; bit 32 reports clipping
	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		begin
			if (v > 64'sd2147483647)
				sat32 = {1'b1, 32'h7FFF_FFFF};
			else if (v < -64'sd2147483648)
				sat32 = {1'b1, 32'h8000_0000};
			else
				sat32 = {1'b0, v[31:0]};
		end
	endfunction

endpackage

[rtl/qfpi_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfpi_lane: one quadrature point lane
// Holds one matrix row in local memory and two point sums; scales a node
// sample pair by its matrix entry and adds into the sums.
// ----------------------------------------------------------------------------
module qfpi_lane import qfpi_pkg::*; #(
	parameter int MAX_NODES = MaxNodesDef,
	localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [NW-1:0]        wr_addr,
	input  logic signed [31:0]   wr_data,
	input  logic [NW-1:0]        rd_addr,
	input  logic signed [31:0]   s1,
	input  logic signed [31:0]   s2,
	input  logic                 mac_en,
	input  logic                 clr,
	output logic signed [63:0]   sum_one,
	output logic signed [63:0]   sum_two
);

	logic signed [31:0] row_mem [MAX_NODES];
	logic signed [31:0] coef_s1;
	logic signed [63:0] p1_s2, p2_s2;
	logic               mac_s1, mac_s2;
	logic signed [63:0] sum_one_q, sum_two_q;

	// Row memory: one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			row_mem[wr_addr] <= wr_data;
		coef_s1 <= row_mem[rd_addr];
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		p1_s2 <= 64'(coef_s1) * 64'(s1);
		p2_s2 <= 64'(coef_s1) * 64'(s2);
	end

	// Accumulate stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1    <= 1'b0;
			mac_s2    <= 1'b0;
			sum_one_q <= '0;
			sum_two_q <= '0;
		end else begin
			mac_s1 <= mac_en;
			mac_s2 <= mac_s1;
			if (clr) begin
				sum_one_q <= '0;
				sum_two_q <= '0;
			end else if (mac_s2) begin
				sum_one_q <= sum_one_q + 64'(round_q16(p1_s2));
				sum_two_q <= sum_two_q + 64'(round_q16(p2_s2));
			end
		end
	end

	assign sum_one = sum_one_q;
	assign sum_two = sum_two_q;

endmodule

[rtl/qfpi_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfpi_merge: cell-end combine of lane results
// Walks the lanes one point a step: saturate, multiply, weigh with rounding,
// and add into the saturating running total.
// ----------------------------------------------------------------------------
module qfpi_merge import qfpi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic signed [63:0]   sum_one,
	input  logic signed [63:0]   sum_two,
	input  logic signed [31:0]   weight,
	input  logic                 take_total,
	output logic signed [63:0]   total,
	output logic                 clip
);

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0] a_s1, b_s1, w_s1, w_s2;
	logic               c_s1, c_s2;
	logic signed [63:0] prod_s2;
	logic               neg_s3, c_s3;
	logic [63:0]        mp_s3;
	logic [31:0]        mw_s3;
	logic [63:0]        hi_s4, lo_s4;
	logic               neg_s4, c_s4;
	logic signed [63:0] total_q;
	logic               clip_q;
	logic [32:0]        sa, sb;
	logic [63:0]        mag, lim, lo_r;
	logic               ovf;
	logic signed [63:0] term;
	logic signed [64:0] wide;

	assign sa = sat32(sum_one);
	assign sb = sat32(sum_two);

	always_ff @(posedge clk) begin
		a_s1    <= sa[31:0];
		b_s1    <= sb[31:0];
		w_s1    <= weight;
		prod_s2 <= 64'(a_s1) * 64'(b_s1);
		w_s2    <= w_s1;
		neg_s3  <= (prod_s2 < 0) != (w_s2 < 0);
		mp_s3   <= prod_s2[63] ? 64'(-prod_s2) : prod_s2;
		mw_s3   <= w_s2[31] ? 32'(-w_s2) : w_s2;
		hi_s4   <= 64'(mp_s3[63:32]) * 64'(mw_s3);
		lo_s4   <= 64'(mp_s3[31:0]) * 64'(mw_s3);
		neg_s4  <= neg_s3;
	end

	// Weigh: (hi << 8) + round(lo >> 24), clipped to the signed range
	always_comb begin
		lo_r = (lo_s4 + 64'h80_0000) >> 24;
		lim  = neg_s4 ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		ovf  = 1'b0;
		if (hi_s4 >= 64'h0080_0000_0000_0000) begin
			mag = lim;
			ovf = 1'b1;
		end else begin
			mag = (hi_s4 << 8) + lo_r;
			if (mag > lim) begin
				mag = lim;
				ovf = 1'b1;
			end
		end
		term = neg_s4 ? -mag : mag;
		wide = 65'(total_q) + 65'(term);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			c_s1 <= 1'b0; c_s2 <= 1'b0; c_s3 <= 1'b0; c_s4 <= 1'b0;
			total_q <= '0;
			clip_q  <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			c_s1 <= in_vld & (sa[32] | sb[32]);
			c_s2 <= c_s1;
			c_s3 <= c_s2;
			c_s4 <= c_s3;
			if (take_total) begin
				total_q <= '0;
				clip_q  <= 1'b0;
			end else if (v_s4) begin
				// Saturating add into the total
				if (wide[64] != wide[63]) begin
					total_q <= wide[64] ? 64'h8000_0000_0000_0000
						: 64'h7FFF_FFFF_FFFF_FFFF;
					clip_q  <= 1'b1;
				end else begin
					total_q <= wide[63:0];
					clip_q  <= clip_q | ovf | c_s4;
				end
			end
		end
	end

	assign total = total_q;
	assign clip  = clip_q;

endmodule

[rtl/quadrature_field_product_integral.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_field_product_integral: quadrature inner product of two fields
//
// Channel  | Dir | Handshake        | Payload
// in       | in  | in_valid/ready   | kind, indexes, coeff_value, samples, last
// out      | out | out_valid/ready  | integral, saturated
// cfg      | in  | cfg_we           | cfg_index, cfg_data
//
// A load is written on acceptance. A sample steps through accept, read,
// multiply, accumulate in every lane below the point count at once, and a
// return to idle; a cell-ending sample adds the merge walk and pipeline
// drain, and a hand-over of the result when last_cell is set. One item at a
// time; a result still waiting at the output holds the block at that
// hand-over. Reset clears control, sums and total; matrix and weights are
// undefined until loaded.
// ----------------------------------------------------------------------------
module quadrature_field_product_integral import qfpi_pkg::*; #(
	parameter int MAX_NODES = MaxNodesDef,
	parameter int MAX_QUAD  = MaxQuadDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [5:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [4:0]          quad_index,
	input  logic [4:0]          node_index,
	input  logic signed [31:0]  coeff_value,
	input  logic signed [31:0]  sample_one,
	input  logic signed [31:0]  sample_two,
	input  logic                last_cell,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [63:0]  integral,
	output logic                saturated
);

	localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int QW = (MAX_QUAD > 1) ? $clog2(MAX_QUAD) : 1;
	localparam int NC = $clog2(MAX_NODES + 1);
	localparam int QC = $clog2(MAX_QUAD + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAC  = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_TAIL = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [5:0]  num_nodes_q, num_quad_q;
	logic [2:0]  state_q;
	logic [1:0]  wait_q;
	logic [3:0]  tail_q;
	logic [NC-1:0] node_cnt_q;
	logic [QC-1:0] walk_q;
	logic        end_cell_q, last_q;
	logic signed [31:0] s1_q, s2_q;
	logic [NW-1:0] rd_node_q;
	logic signed [31:0] weights [MAX_QUAD];
	logic signed [31:0] w_rd;
	logic signed [63:0] lsum_one [MAX_QUAD];
	logic signed [63:0] lsum_two [MAX_QUAD];
	logic        mac_pulse, clr_pulse, walk_vld, take_total;
	logic signed [63:0] m_one, m_two, total;
	logic        clip, out_valid_q;
	logic signed [63:0] integral_q;
	logic        sat_q;
	logic [NC-1:0] nn;
	logic [QC-1:0] nq;
	logic [NC-1:0] cur_node;
	logic        accept, q_ok, n_ok;
	logic        emit_go;

	// Clamp counts: zero acts as one, above the maximum clamps
	always_comb begin
		if (num_nodes_q == 6'd0)
			nn = NC'(1);
		else if (32'(num_nodes_q) > MAX_NODES)
			nn = NC'(MAX_NODES);
		else
			nn = NC'(num_nodes_q);
		if (num_quad_q == 6'd0)
			nq = QC'(1);
		else if (32'(num_quad_q) > MAX_QUAD)
			nq = QC'(MAX_QUAD);
		else
			nq = QC'(num_quad_q);
		cur_node = (node_cnt_q >= nn) ? nn - NC'(1) : node_cnt_q;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign q_ok     = 32'(quad_index) < MAX_QUAD;
	assign n_ok     = 32'(node_index) < MAX_NODES;
	assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_nodes_q <= 6'd4;
			num_quad_q  <= 6'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_NODES: num_nodes_q <= cfg_data;
				REG_NUM_QUAD:  num_quad_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Weight store, read by the merge walk
	always_ff @(posedge clk) begin
		if (accept && kind == KIND_WEIGHT && q_ok)
			weights[QW'(quad_index)] <= coeff_value;
		w_rd <= weights[walk_q[QW-1:0]];
	end

	// Lanes
	for (genvar g = 0; g < MAX_QUAD; g++) begin : g_lane
		qfpi_lane #(.MAX_NODES(MAX_NODES)) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (accept && kind == KIND_MATRIX && q_ok && n_ok
				&& 32'(quad_index) == g),
			.wr_addr (NW'(node_index)),
			.wr_data (coeff_value),
			.rd_addr (rd_node_q),
			.s1      (s1_q),
			.s2      (s2_q),
			.mac_en  (mac_pulse && g < 32'(nq)),
			.clr     (clr_pulse),
			.sum_one (lsum_one[g]),
			.sum_two (lsum_two[g])
		);
	end

	// Select the lane under the walk pointer, registered
	always_ff @(posedge clk) begin
		m_one <= lsum_one[walk_q[QW-1:0]];
		m_two <= lsum_two[walk_q[QW-1:0]];
	end

	qfpi_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (walk_vld),
		.sum_one    (m_one),
		.sum_two    (m_two),
		.weight     (w_rd),
		.take_total (take_total),
		.total      (total),
		.clip       (clip)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= '0;
			tail_q      <= '0;
			node_cnt_q  <= '0;
			walk_q      <= '0;
			end_cell_q  <= 1'b0;
			last_q      <= 1'b0;
			mac_pulse   <= 1'b0;
			clr_pulse   <= 1'b0;
			walk_vld    <= 1'b0;
			take_total  <= 1'b0;
			out_valid_q <= 1'b0;
			sat_q       <= 1'b0;
			integral_q  <= '0;
		end else begin
			mac_pulse  <= accept && kind == KIND_SAMPLE;
			clr_pulse  <= (state_q == ST_TAIL) && (tail_q == 4'd0);
			walk_vld   <= (state_q == ST_WALK);
			take_total <= emit_go;
			// Raise on hand-over, drop once the result transfer is taken
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && kind == KIND_SAMPLE) begin
						s1_q       <= sample_one;
						s2_q       <= sample_two;
						rd_node_q  <= cur_node[NW-1:0];
						end_cell_q <= (cur_node + NC'(1)) >= nn;
						node_cnt_q <= cur_node + NC'(1);
						last_q     <= last_cell;
						wait_q     <= 2'd3;
						state_q    <= ST_MAC;
					end
				end
				ST_MAC: begin
					// Wait for the lanes' read, multiply and add
					if (wait_q != 2'd0)
						wait_q <= wait_q - 2'd1;
					else if (end_cell_q) begin
						walk_q  <= '0;
						state_q <= ST_WALK;
					end else
						state_q <= ST_IDLE;
				end
				ST_WALK: begin
					// Feed one point a cycle; lane data and weight are registered into the merge the cycle after
					if (walk_q + QC'(1) >= nq) begin
						tail_q  <= 4'd7;
						state_q <= ST_TAIL;
					end else
						walk_q <= walk_q + QC'(1);
				end
				ST_TAIL: begin
					// Drain the merge pipeline
					if (tail_q != 4'd0)
						tail_q <= tail_q - 4'd1;
					else begin
						node_cnt_q <= '0;
						state_q    <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						integral_q <= total;
						sat_q      <= clip;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign integral  = integral_q;
	assign saturated = sat_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quadrature_field_product_integral
// Loads matrix entries and weights, streams cells of node sample pairs under
// several node and point counts (extremes included), and predicts each
// emitted integral and its clip flag bit for bit. Both channels stall and
// idle in random bursts; every result is compared field by field.
// ----------------------------------------------------------------------------
import qfpi_pkg::*;

localparam logic [1:0] KIND_UNUSED = 2'd3;

typedef struct {
	logic [1:0]         kind;
	logic [4:0]         quad_index;
	logic [4:0]         node_index;
	logic signed [31:0] coeff_value;
	logic signed [31:0] sample_one;
	logic signed [31:0] sample_two;
	logic               last_cell;
} feed_t;

typedef struct {
	logic signed [63:0] integral;
	logic               saturated;
} integral_t;

class integral_scoreboard;
	logic signed [31:0] coeffs [1024];
	logic signed [31:0] weights [32];
	longint             sum_one [32];
	longint             sum_two [32];
	int unsigned        node_pos;
	longint             total;
	bit                 clipped;
	bit [5:0]           nodes_reg;
	bit [5:0]           quads_reg;
	integral_t          awaited [$];
	int                 errors;
	int                 results;

	function new();
		for (int i = 0; i < 1024; i++) coeffs[i] = '0;
		for (int i = 0; i < 32; i++) begin
			weights[i] = '0;
			sum_one[i] = 0;
			sum_two[i] = 0;
		end
		node_pos  = 0;
		total     = 0;
		clipped   = 0;
		nodes_reg = 6'd4;
		quads_reg = 6'd4;
		errors    = 0;
		results   = 0;
	endfunction

	function int unsigned eff(bit [5:0] v);
		if (v == 0) return 1;
		return (v > 32) ? 32 : v;
	endfunction

	function void set_reg(logic [0:0] idx, bit [5:0] val);
		if (idx == REG_NUM_NODES) nodes_reg = val;
		else quads_reg = val;
	endfunction

	function longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			clipped = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clipped = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// scale a Q32.32 product by a Q8.24 weight, round half away from zero;
	// an upper partial product at or past 2^55 always clips
	function longint weigh(longint p, logic signed [31:0] w);
		logic signed [127:0] pe;
		logic signed [127:0] we;
		logic signed [127:0] prod;
		logic [127:0]        mag;
		logic [127:0]        lim;
		logic [127:0]        hi;
		bit                  neg;
		pe   = 128'(p);
		we   = 128'(w);
		prod = pe * we;
		neg  = prod < 0;
		mag  = neg ? -prod : prod;
		hi   = ((pe < 0 ? -pe : pe) >> 32) * (we < 0 ? -we : we);
		mag  = (mag + 128'd8388608) >> 24;
		lim  = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
		if (hi >= (128'd1 << 55) || mag > lim) begin
			mag     = lim;
			clipped = 1;
		end
		return neg ? -mag[63:0] : mag[63:0];
	endfunction

	function void add_total(longint t);
		logic signed [64:0] s;
		s = $signed({total[63], total}) + $signed({t[63], t});
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
			total   = 64'h7FFF_FFFF_FFFF_FFFF;
			clipped = 1;
		end else if (s < -65'sh0_8000_0000_0000_0000) begin
			total   = 64'h8000_0000_0000_0000;
			clipped = 1;
		end else begin
			total = s[63:0];
		end
	endfunction

	// advance the model by one accepted transfer
	function void absorb(feed_t f);
		int unsigned nn;
		int unsigned nq;
		longint      m;
		integral_t   r;
		nn = eff(nodes_reg);
		nq = eff(quads_reg);
		case (f.kind)
			KIND_MATRIX: coeffs[f.quad_index * 32 + f.node_index] = f.coeff_value;
			KIND_WEIGHT: weights[f.quad_index] = f.coeff_value;
			KIND_SAMPLE: begin
				if (node_pos >= nn) node_pos = nn - 1;
				for (int i = 0; i < nq; i++) begin
					m = coeffs[i * 32 + node_pos];
					sum_one[i] += (m * longint'(f.sample_one) + 64'sd536870912) >>> 30;
					sum_two[i] += (m * longint'(f.sample_two) + 64'sd536870912) >>> 30;
				end
				node_pos++;
				if (node_pos >= nn) begin
					for (int i = 0; i < nq; i++)
						add_total(weigh(clip32(sum_one[i]) * clip32(sum_two[i]), weights[i]));
					for (int i = 0; i < 32; i++) begin
						sum_one[i] = 0;
						sum_two[i] = 0;
					end
					node_pos = 0;
					if (f.last_cell) begin
						r.integral  = total;
						r.saturated = clipped;
						awaited.push_back(r);
						total   = 0;
						clipped = 0;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function void compare_integral(logic signed [63:0] integral, logic saturated);
		integral_t e;
		results++;
		if (awaited.size() == 0) begin
			$error("unexpected result: integral %0d saturated %0b", integral, saturated);
			errors++;
			return;
		end
		e = awaited.pop_front();
		if (integral !== e.integral) begin
			$error("integral: expected %0d, got %0d", e.integral, integral);
			errors++;
		end
		if (saturated !== e.saturated) begin
			$error("saturated: expected %0b, got %0b", e.saturated, saturated);
			errors++;
		end
	endfunction
endclass

module testbench;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN       = MaxQuadDef + 16;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [0:0]         cfg_index = '0;
	logic [5:0]         cfg_data = '0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         kind = '0;
	logic [4:0]         quad_index = '0;
	logic [4:0]         node_index = '0;
	logic signed [31:0] coeff_value = '0;
	logic signed [31:0] sample_one = '0;
	logic signed [31:0] sample_two = '0;
	logic               last_cell = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [63:0] integral;
	logic               saturated;

	integral_scoreboard sb;
	bit   coeff_set [1024];
	bit   weight_set [32];
	int   fed;
	int   quiet_cycles;
	int   stall_left;
	bit   calm;
	bit   idle_on;

	quadrature_field_product_integral i_dut (.*);

	always #5 clk = ~clk;

	// pick a word: full range, scaled down, or an extreme
	function automatic logic signed [31:0] rand_word();
		logic signed [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 5))
			0, 1: return v;
			2: return 32'sh7FFF_FFFF;
			3: return 32'sh8000_0000;
			default: return v >>> $urandom_range(4, 30);
		endcase
	endfunction

	// drive one transfer and wait for it to be taken
	task automatic send(logic [1:0] k, logic [4:0] q, logic [4:0] n, logic signed [31:0] c,
			logic signed [31:0] a, logic signed [31:0] b, logic lc);
		feed_t f;
		int    gap;
		gap = (!calm && idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		f = '{k, q, n, c, a, b, lc};
		in_valid    <= 1;
		kind        <= k;
		quad_index  <= q;
		node_index  <= n;
		coeff_value <= c;
		sample_one  <= a;
		sample_two  <= b;
		last_cell   <= lc;
		do @(posedge clk); while (!in_ready);
		sb.absorb(f);
		if (k == KIND_MATRIX) coeff_set[q * 32 + n] = 1;
		if (k == KIND_WEIGHT) weight_set[q] = 1;
		fed++;
	endtask

	task automatic load_coeff(int q, int n, logic signed [31:0] c);
		send(KIND_MATRIX, 5'(q), 5'(n), c, $urandom, $urandom, 1'($urandom_range(0, 1)));
	endtask

	task automatic load_weight(int q, logic signed [31:0] c);
		send(KIND_WEIGHT, 5'(q), 5'($urandom), c, $urandom, $urandom,
			1'($urandom_range(0, 1)));
	endtask

	task automatic send_sample(logic signed [31:0] a, logic signed [31:0] b, logic lc);
		send(KIND_SAMPLE, 5'($urandom), 5'($urandom), $urandom, a, b, lc);
	endtask

	// hold input until every result has come and the block has gone quiet
	task automatic settle();
		in_valid <= 0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [5:0] val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	// load every entry the current counts can read that is still unwritten
	task automatic load_needed();
		for (int q = 0; q < sb.eff(sb.quads_reg); q++) begin
			if (!weight_set[q]) load_weight(q, rand_word());
			for (int n = 0; n < sb.eff(sb.nodes_reg); n++)
				if (!coeff_set[q * 32 + n]) load_coeff(q, n, rand_word());
		end
	endtask

	function automatic logic [5:0] pick_count();
		case ($urandom_range(0, 9))
			0: return 6'd0;
			1: return 6'd63;
			2: return 6'd32;
			3: return 6'd1;
			default: return 6'($urandom_range(2, 6));
		endcase
	endfunction

	// receive side: check transfers, stall in bursts
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.compare_integral(integral, saturated);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 0;
		end else if (!calm && idle_on && $urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(0, 12);
			out_ready  <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		int phase_len;
		int nn;
		sb           = new();
		fed          = 0;
		quiet_cycles = 0;
		stall_left   = 0;
		calm         = 0;
		idle_on      = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: one node and one point, zero count acting as one
		write_reg(REG_NUM_NODES, 6'd0);
		write_reg(REG_NUM_QUAD, 6'd1);
		load_coeff(0, 0, 32'sh7FFF_FFFF);
		load_weight(0, 32'sh7FFF_FFFF);
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
		load_coeff(0, 0, 32'sh8000_0000);
		load_weight(0, 32'sh8000_0000);
		send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1);
		send_sample(32'sh8000_0000, 32'sh8000_0000, 1);
		send(KIND_UNUSED, 5'd31, 5'd31, 32'sh7FFF_FFFF, '1, '1, 1);
		load_coeff(31, 31, 32'sh4000_0000);
		load_weight(31, 32'sh0100_0000);
		load_coeff(0, 0, 32'sh4000_0000);
		load_weight(0, 32'sh0100_0000);
		send_sample(32'sh0001_0000, 32'sh0000_0000, 1);
		send_sample(32'sh0003_0000, -32'sh0002_0000, 1);
		settle();
		// two nodes: flag on the first node must not count
		write_reg(REG_NUM_NODES, 6'd2);
		load_coeff(0, 1, 32'shC000_0000);
		send_sample(32'sh0005_0000, 32'sh0007_0000, 1);
		send_sample(32'sh0002_0000, 32'sh0001_8000, 0);
		send_sample(32'sh0001_0000, 32'sh0001_0000, 0);
		send_sample(-32'sh0001_0000, 32'sh0004_0000, 1);
		// shrink the count in the middle of a cell
		send_sample(32'sh0009_0000, 32'sh0002_0000, 0);
		settle();
		write_reg(REG_NUM_NODES, 6'd1);
		send_sample(32'sh0001_0000, 32'sh0003_0000, 1);

		// random phases of well-formed cells with loads and noise between them
		while (fed < 1800) begin
			settle();
			write_reg(REG_NUM_NODES, pick_count());
			write_reg(REG_NUM_QUAD, pick_count());
			load_needed();
			idle_on   = $urandom_range(0, 3) != 0;
			calm      = fed > 1550;
			phase_len = $urandom_range(60, 200);
			nn        = sb.eff(sb.nodes_reg);
			for (int j = 0; j < phase_len; ) begin
				case ($urandom_range(0, 19))
					14, 15: begin
						load_coeff($urandom_range(0, 31), $urandom_range(0, 31), rand_word());
						j++;
					end
					16, 17: begin
						load_weight($urandom_range(0, 31), rand_word());
						j++;
					end
					18: begin
						send(KIND_UNUSED, 5'($urandom), 5'($urandom), $urandom, $urandom,
							$urandom, 1'($urandom_range(0, 1)));
					end
					19: begin
						send_sample(rand_word(), rand_word(), 1'($urandom_range(0, 1)));
						j++;
					end
					default: begin
						for (int k = 0; k < nn; k++)
							send_sample(rand_word(), rand_word(),
								(k == nn - 1) ? ($urandom_range(0, 2) != 0)
								: 1'($urandom_range(0, 1)));
						j += nn;
					end
				endcase
			end
		end

		in_valid <= 0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("covered %0d transfers in, %0d integrals out, counts 0 to 63 on both registers",
			fed, sb.results);
		$display("with loads, unused kind, mid-cell count change and random stalls on both sides");
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

[quadrature_field_product_integral.f]
rtl/qfpi_pkg.sv
rtl/qfpi_lane.sv
rtl/qfpi_merge.sv
rtl/quadrature_field_product_integral.sv
tb/testbench.sv
